>>> src/gpsr_pkg.sv
// Shared types and constants for the game-pad serial responder.
// No dependencies; every other file in src refers to it by scoped names.
`default_nettype none

package gpsr_pkg;

    // Request kinds carried in the slave-side tuser
    typedef enum logic [1:0] {
        OP_FRAME  = 2'd0,
        OP_BYTE   = 2'd1,
        OP_LOAD   = 2'd2,
        OP_TOGGLE = 2'd3
    } op_t;

    // Motor event kinds carried in the master-side tuser
    localparam logic [1:0] MOTOR_NONE  = 2'd0;
    localparam logic [1:0] MOTOR_SMALL = 2'd1;
    localparam logic [1:0] MOTOR_BIG   = 2'd2;

    // Host commands
    localparam logic [7:0] CMD_READ   = 8'h42;
    localparam logic [7:0] CMD_CONFIG = 8'h43;
    localparam logic [7:0] CMD_SETMOD = 8'h44;
    localparam logic [7:0] CMD_MODEL  = 8'h45;
    localparam logic [7:0] CMD_ACT    = 8'h46;
    localparam logic [7:0] CMD_COMB   = 8'h47;
    localparam logic [7:0] CMD_QMODE  = 8'h4c;
    localparam logic [7:0] CMD_ALIGN  = 8'h4d;

    // Fixed reply bytes
    localparam logic [7:0] ID_CONFIG   = 8'hf3;
    localparam logic [7:0] ID_DIGITAL  = 8'h41;
    localparam logic [7:0] ID_ANALOG   = 8'h53;
    localparam logic [7:0] ACK_BYTE    = 8'h5a;
    localparam logic [7:0] IDLE_BYTE   = 8'hff;
    localparam logic [7:0] ACT_STRONG  = 8'h14;
    localparam logic [7:0] ACT_WEAK    = 8'h0a;
    localparam logic [7:0] SETMOD_ANA  = 8'h01;
    localparam logic [7:0] SETMOD_LOCK = 8'h03;

    // Frame lengths in data bytes
    localparam logic [2:0] FLEN_SHORT = 3'd2;
    localparam logic [2:0] FLEN_LONG  = 3'd6;

    // Register indexes on the configuration port
    localparam logic [1:0] REG_DIGITAL_CODE = 2'd0;
    localparam logic [1:0] REG_ANALOG_CODE  = 2'd1;
    localparam logic [1:0] REG_PORT0_START  = 2'd2;
    localparam logic [1:0] REG_PORT1_START  = 2'd3;

    localparam logic [7:0] DIGITAL_CODE_RESET = 8'h04;
    localparam logic [7:0] ANALOG_CODE_RESET  = 8'h07;

    // Six pad bytes of one port, byte 0 = first button byte
    typedef logic [5:0][7:0] pad_set_t;
    localparam pad_set_t PAD_RESET = {8'h7f, 8'h7f, 8'h7f, 8'h7f, 8'hff, 8'hff};

    typedef struct packed {
        op_t          op;
        logic         port;
        logic [7:0]   host_byte;
        pad_set_t     pad;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  reply_byte;
        logic [1:0]  motor_kind;
        logic [15:0] motor_strength;
        logic        analog_led;
    } result_t;

    // Configuration values and start-mode write strobes
    typedef struct packed {
        logic [7:0] digital_code;
        logic [7:0] analog_code;
        logic [1:0] start_wr;
        logic [1:0] start_val;
    } cfg_t;

endpackage

`default_nettype wire

>>> src/gpsr_cfg_regs.sv
// APB register file: mode codes and per-port start modes.
// Depends on gpsr_pkg for register indexes and the cfg_t bundle.
`default_nettype none

module gpsr_cfg_regs (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [3:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output gpsr_pkg::cfg_t     cfg
);

    logic [7:0] digital_code_reg;
    logic [7:0] analog_code_reg;
    logic       start0_reg;
    logic       start1_reg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    // Update registers on the access phase of a write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            digital_code_reg <= gpsr_pkg::DIGITAL_CODE_RESET;
            analog_code_reg  <= gpsr_pkg::ANALOG_CODE_RESET;
            start0_reg       <= 1'b0;
            start1_reg       <= 1'b0;
        end else if (wr_en) begin
            unique case (reg_idx)
                gpsr_pkg::REG_DIGITAL_CODE: digital_code_reg <= pwdata[7:0];
                gpsr_pkg::REG_ANALOG_CODE:  analog_code_reg  <= pwdata[7:0];
                gpsr_pkg::REG_PORT0_START:  start0_reg       <= pwdata[0];
                gpsr_pkg::REG_PORT1_START:  start1_reg       <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        unique case (reg_idx)
            gpsr_pkg::REG_DIGITAL_CODE: prdata = {24'd0, digital_code_reg};
            gpsr_pkg::REG_ANALOG_CODE:  prdata = {24'd0, analog_code_reg};
            gpsr_pkg::REG_PORT0_START:  prdata = {31'd0, start0_reg};
            gpsr_pkg::REG_PORT1_START:  prdata = {31'd0, start1_reg};
            default:                    prdata = 32'd0;
        endcase
    end

    // A start-mode write also sets that port's mode at once
    assign cfg.digital_code = digital_code_reg;
    assign cfg.analog_code  = analog_code_reg;
    assign cfg.start_wr[0]  = wr_en && (reg_idx == gpsr_pkg::REG_PORT0_START);
    assign cfg.start_wr[1]  = wr_en && (reg_idx == gpsr_pkg::REG_PORT1_START);
    assign cfg.start_val    = {pwdata[0], pwdata[0]};

endmodule

`default_nettype wire

>>> src/gpsr_core.sv
// Protocol state and single-pass reply logic for one request per cycle.
// Depends on gpsr_pkg for commands, reply constants and bundles.
`default_nettype none

module gpsr_core (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               fire,
    input  gpsr_pkg::in_item_t      item,
    input  gpsr_pkg::cfg_t          cfg,
    output gpsr_pkg::result_t       res
);

    // Per-port state
    logic [1:0]         analog_reg, analog_next;
    logic [1:0]         in_cfg_reg, in_cfg_next;
    logic [1:0]         locked_reg, locked_next;
    logic [1:0]         mode_chg_reg, mode_chg_next;
    gpsr_pkg::pad_set_t pad_reg  [2];
    gpsr_pkg::pad_set_t pad_next [2];

    // Frame state
    logic       active_port_reg, active_port_next;
    logic [7:0] cmd_reg, cmd_next;
    logic [7:0] pos_reg, pos_next;
    logic [2:0] flen_reg, flen_next;
    logic [7:0] saved_reg, saved_next;

    // Decode helpers
    logic       p;
    logic [7:0] d;
    logic       is_query;
    logic [2:0] flen_eff;
    logic       in_frame;
    logic [2:0] pad_idx;
    logic [7:0] pad_rd;
    logic [2:0] apply_at;
    logic       led_port;

    // Data-byte decode shared by all commands
    always_comb begin
        p        = active_port_reg;
        d        = pos_reg - 8'd2;
        is_query = (cmd_reg == gpsr_pkg::CMD_SETMOD) || (cmd_reg == gpsr_pkg::CMD_MODEL) ||
                   (cmd_reg == gpsr_pkg::CMD_ACT)    || (cmd_reg == gpsr_pkg::CMD_COMB)  ||
                   (cmd_reg == gpsr_pkg::CMD_QMODE)  || (cmd_reg == gpsr_pkg::CMD_ALIGN);
        flen_eff = (!in_cfg_reg[p] && is_query) ? gpsr_pkg::FLEN_LONG : flen_reg;
        in_frame = {5'd0, flen_eff} > d;
        pad_idx  = in_frame ? d[2:0] : 3'd0;
        pad_rd   = pad_reg[p][pad_idx];
        apply_at = (flen_eff > 3'd2) ? (flen_eff - 3'd2) : 3'd1;
    end

    // Next state and result
    always_comb begin
        analog_next      = analog_reg;
        in_cfg_next      = in_cfg_reg;
        locked_next      = locked_reg;
        mode_chg_next    = mode_chg_reg;
        pad_next         = pad_reg;
        active_port_next = active_port_reg;
        cmd_next         = cmd_reg;
        pos_next         = pos_reg;
        flen_next        = flen_reg;
        saved_next       = saved_reg;
        res              = '0;
        led_port         = item.port;

        if (fire) begin
            unique case (item.op)
                gpsr_pkg::OP_FRAME: begin
                    active_port_next = item.port;
                    pos_next         = 8'd0;
                    res.reply_byte   = gpsr_pkg::IDLE_BYTE;
                end
                gpsr_pkg::OP_BYTE: begin
                    led_port = p;
                    pos_next = (pos_reg == 8'hff) ? pos_reg : pos_reg + 8'd1;
                    priority if (pos_reg == 8'd0) begin
                        // Command byte: latch command, answer with the pad id
                        cmd_next  = item.host_byte;
                        flen_next = (in_cfg_reg[p] || analog_reg[p]) ?
                                    gpsr_pkg::FLEN_LONG : gpsr_pkg::FLEN_SHORT;
                        if (in_cfg_reg[p]) begin
                            res.reply_byte = gpsr_pkg::ID_CONFIG;
                        end else if (analog_reg[p]) begin
                            res.reply_byte = gpsr_pkg::ID_ANALOG;
                        end else begin
                            res.reply_byte = gpsr_pkg::ID_DIGITAL;
                        end
                    end else if (pos_reg == 8'd1) begin
                        res.reply_byte   = mode_chg_reg[p] ? 8'h00 : gpsr_pkg::ACK_BYTE;
                        mode_chg_next[p] = 1'b0;
                    end else begin
                        flen_next = flen_eff;
                        if (in_frame) begin
                            if (d == 8'd0) begin
                                saved_next = item.host_byte;
                            end
                            unique case (cmd_reg)
                                gpsr_pkg::CMD_READ: begin
                                    res.reply_byte = pad_rd;
                                    if (d == 8'd1) begin
                                        res.motor_kind     = gpsr_pkg::MOTOR_SMALL;
                                        res.motor_strength = (item.host_byte != 8'd0) ?
                                                             16'hffff : 16'h0000;
                                    end else if (d == 8'd0) begin
                                        res.motor_kind     = gpsr_pkg::MOTOR_BIG;
                                        res.motor_strength = {item.host_byte, 8'h00};
                                    end
                                end
                                gpsr_pkg::CMD_CONFIG: begin
                                    res.reply_byte = in_cfg_reg[p] ? 8'h00 : pad_rd;
                                    if (d != 8'd0 && d == {5'd0, apply_at}) begin
                                        in_cfg_next[p] = (saved_reg != 8'd0);
                                    end
                                end
                                gpsr_pkg::CMD_MODEL: begin
                                    unique case (d)
                                        8'd0:    res.reply_byte = 8'h01;
                                        8'd1:    res.reply_byte = 8'h02;
                                        8'd2:    res.reply_byte = {7'd0, analog_reg[p]};
                                        8'd3:    res.reply_byte = 8'h02;
                                        8'd4:    res.reply_byte = 8'h01;
                                        default: res.reply_byte = 8'h00;
                                    endcase
                                end
                                gpsr_pkg::CMD_ACT: begin
                                    unique case (d)
                                        8'd3: res.reply_byte = (saved_reg != 8'd0) ?
                                                               8'h00 : 8'h02;
                                        8'd4: res.reply_byte = (saved_reg != 8'd0) ?
                                                               8'h01 : 8'h00;
                                        8'd5: res.reply_byte = (saved_reg != 8'd0) ?
                                                               gpsr_pkg::ACT_STRONG :
                                                               gpsr_pkg::ACT_WEAK;
                                        default: res.reply_byte = 8'h00;
                                    endcase
                                end
                                gpsr_pkg::CMD_COMB: begin
                                    res.reply_byte = (d == 8'd2) ? 8'h02 : 8'h00;
                                end
                                gpsr_pkg::CMD_QMODE: begin
                                    if (d == 8'd3) begin
                                        res.reply_byte = (saved_reg != 8'd0) ?
                                                         cfg.analog_code : cfg.digital_code;
                                    end
                                end
                                gpsr_pkg::CMD_SETMOD: begin
                                    // Mark a mode or lock change for the next frame
                                    if (d == 8'd0) begin
                                        analog_next[p] = (item.host_byte == gpsr_pkg::SETMOD_ANA);
                                        if (analog_next[p] != analog_reg[p]) begin
                                            mode_chg_next[p] = 1'b1;
                                        end
                                    end else if (d == 8'd1) begin
                                        locked_next[p] =
                                            (item.host_byte == gpsr_pkg::SETMOD_LOCK);
                                        if (locked_next[p] != locked_reg[p]) begin
                                            mode_chg_next[p] = 1'b1;
                                        end
                                    end
                                end
                                gpsr_pkg::CMD_ALIGN: begin
                                    if (d == 8'd0) begin
                                        res.reply_byte = 8'h00;
                                    end else if (d == 8'd1) begin
                                        res.reply_byte = 8'h01;
                                    end else begin
                                        res.reply_byte = 8'hff;
                                    end
                                end
                                default: res.reply_byte = 8'h00;
                            endcase
                        end
                    end
                end
                gpsr_pkg::OP_LOAD: begin
                    pad_next[item.port] = item.pad;
                end
                gpsr_pkg::OP_TOGGLE: begin
                    analog_next[item.port] = !analog_reg[item.port];
                end
                default: ;
            endcase
        end

        // Start-mode writes are to arrive only while idle; the core does not enforce it
        if (cfg.start_wr[0]) begin
            analog_next[0] = cfg.start_val[0];
        end
        if (cfg.start_wr[1]) begin
            analog_next[1] = cfg.start_val[1];
        end

        res.analog_led = analog_next[led_port];
    end

    // Hold state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            analog_reg      <= 2'b00;
            in_cfg_reg      <= 2'b00;
            locked_reg      <= 2'b00;
            mode_chg_reg    <= 2'b00;
            pad_reg[0]      <= gpsr_pkg::PAD_RESET;
            pad_reg[1]      <= gpsr_pkg::PAD_RESET;
            active_port_reg <= 1'b0;
            cmd_reg         <= 8'd0;
            pos_reg         <= 8'd0;
            flen_reg        <= 3'd0;
            saved_reg       <= 8'd0;
        end else begin
            analog_reg      <= analog_next;
            in_cfg_reg      <= in_cfg_next;
            locked_reg      <= locked_next;
            mode_chg_reg    <= mode_chg_next;
            pad_reg         <= pad_next;
            active_port_reg <= active_port_next;
            cmd_reg         <= cmd_next;
            pos_reg         <= pos_next;
            flen_reg        <= flen_next;
            saved_reg       <= saved_next;
        end
    end

    // Motor events come only from byte exchanges
    assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && item.op != gpsr_pkg::OP_BYTE) |-> (res.motor_kind == gpsr_pkg::MOTOR_NONE))
        else $error("motor event outside a byte exchange");

    // Frame start rewinds the byte position
    assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && item.op == gpsr_pkg::OP_FRAME) |=> (pos_reg == 8'd0))
        else $error("byte position not cleared by frame start");

    // Frame length is always zero (its reset value) or one of the legal lengths
    assert property (@(posedge aclk) disable iff (!aresetn)
        (flen_reg == 3'd0) || (flen_reg == gpsr_pkg::FLEN_SHORT) ||
        (flen_reg == gpsr_pkg::FLEN_LONG))
        else $error("illegal frame length");

    // The status byte clears the mode-changed mark
    assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && item.op == gpsr_pkg::OP_BYTE && pos_reg == 8'd1)
        |=> !mode_chg_reg[$past(active_port_reg)])
        else $error("mode-changed mark survived the status byte");

    // The saved argument moves only on a byte exchange
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(fire && item.op == gpsr_pkg::OP_BYTE) |=> $stable(saved_reg))
        else $error("saved argument changed without a byte exchange");

endmodule

`default_nettype wire

>>> src/game_pad_serial_responder.sv
// Top level: request and result registers around the responder core,
// plus the APB register file. Depends on gpsr_pkg, gpsr_cfg_regs, gpsr_core.
//
//   channel   direction  handshake             payload
//   s_        in         s_tvalid / s_tready   s_tdata 56 bits, s_tuser 3 bits
//   m_        out        m_tvalid / m_tready   m_tdata 32 bits, m_tuser 2 bits
//   APB       in         psel/penable/pready   paddr 4, pwdata/prdata 32
//
// A request passes from the request register through the core to the result
// register, which answers it. One request per cycle is sustained while m_tready
// is high; the single core pass between the two registers sets that rate.
// Reset (aresetn low, synchronous) empties both registers; there is no clearing pass.
// A stalled result holds the result register, and the request register keeps
// accepting until it is full too.
`default_nettype none

module game_pad_serial_responder (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // request channel
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [7:0] host_byte, [15:8] buttons_first, [23:16] buttons_second,
    // [31:24] right_x, [39:32] right_y, [47:40] left_x, [55:48] left_y
    input  wire logic [55:0] s_tdata,
    // [1:0] op, [2] port
    input  wire logic [2:0]  s_tuser,
    // result channel
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [7:0] reply_byte, [23:8] motor_strength, [24] analog_led, [31:25] zero
    output logic [31:0]      m_tdata,
    // [1:0] motor_kind
    output logic [1:0]       m_tuser,
    // configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    gpsr_pkg::cfg_t     cfg;
    gpsr_pkg::in_item_t in_item_reg;
    gpsr_pkg::result_t  core_res;
    gpsr_pkg::result_t  out_res_reg;
    logic               in_valid_reg, in_valid_next;
    logic               out_valid_reg, out_valid_next;
    logic               s_accept;
    logic               advance;

    gpsr_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    gpsr_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (advance),
        .item    (in_item_reg),
        .cfg     (cfg),
        .res     (core_res)
    );

    // Advance a held request when the result register is free or being drained
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    // Valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the request and the result
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_item_reg.op        <= gpsr_pkg::op_t'(s_tuser[1:0]);
            in_item_reg.port      <= s_tuser[2];
            in_item_reg.host_byte <= s_tdata[7:0];
            in_item_reg.pad       <= s_tdata[55:8];
        end
        if (advance) begin
            out_res_reg <= core_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_res_reg.analog_led, out_res_reg.motor_strength,
                       out_res_reg.reply_byte};
    assign m_tuser  = out_res_reg.motor_kind;

endmodule

`default_nettype wire

>>> tb/tb_game_pad_serial_responder.sv
// Self-checking testbench for game_pad_serial_responder: a directed table, then random
// frames checked against an in-bench predictor. Depends on gpsr_pkg and the RTL top level.
`timescale 1ns / 1ps

module tb_game_pad_serial_responder;

    import gpsr_pkg::*;

    localparam int          PHASE_ITEMS  = 230;
    localparam int          LONG_HOLD    = 60;
    localparam int          TAIL_CYCLES  = 4;
    localparam longint      RUN_LIMIT_NS = 64'd20_000_000;
    localparam logic [7:0]  CMD_UNKNOWN  = 8'h00;
    localparam result_t     NO_CHECK     = '0;

    typedef struct packed {
        op_t        op;
        logic       port;
        logic [7:0] host_byte;
        pad_set_t   pad;
        logic       checked;
        result_t    want;
    } stim_row_t;

    // Directed requests; fixed replies are typed in only where obvious
    localparam stim_row_t SCRIPT [25] = '{
        // command byte with no frame start yet lands on port 0, digital
        '{OP_BYTE,   1'b0, CMD_READ,    '0, 1'b1, '{ID_DIGITAL, MOTOR_NONE, 16'h0000, 1'b0}},
        '{OP_BYTE,   1'b0, 8'h00,       '0, 1'b1, '{ACK_BYTE, MOTOR_NONE, 16'h0000, 1'b0}},
        '{OP_BYTE,   1'b0, 8'hff,       '0, 1'b1, '{8'hff, MOTOR_BIG, 16'hff00, 1'b0}},
        '{OP_BYTE,   1'b0, 8'h01,       '0, 1'b1, '{8'hff, MOTOR_SMALL, 16'hffff, 1'b0}},
        // past the end of a short frame
        '{OP_BYTE,   1'b0, 8'h55,       '0, 1'b1, '{8'h00, MOTOR_NONE, 16'h0000, 1'b0}},
        '{OP_LOAD,   1'b0, 8'h00,       '0, 1'b1, '{8'h00, MOTOR_NONE, 16'h0000, 1'b0}},
        '{OP_LOAD,   1'b1, 8'hff,       '1, 1'b1, '{8'h00, MOTOR_NONE, 16'h0000, 1'b0}},
        '{OP_TOGGLE, 1'b1, 8'h00,       '0, 1'b1, '{8'h00, MOTOR_NONE, 16'h0000, 1'b1}},
        '{OP_FRAME,  1'b1, 8'h00,       '0, 1'b1, '{IDLE_BYTE, MOTOR_NONE, 16'h0000, 1'b1}},
        // model query outside config mode on an analog port
        '{OP_BYTE,   1'b0, CMD_MODEL,   '0, 1'b1, '{ID_ANALOG, MOTOR_NONE, 16'h0000, 1'b1}},
        '{OP_BYTE,   1'b0, 8'h00,       '0, 1'b1, '{ACK_BYTE, MOTOR_NONE, 16'h0000, 1'b1}},
        '{OP_BYTE,   1'b0, 8'h00,       '0, 1'b0, NO_CHECK},
        '{OP_BYTE,   1'b0, 8'h00,       '0, 1'b0, NO_CHECK},
        '{OP_BYTE,   1'b0, 8'h00,       '0, 1'b0, NO_CHECK},
        // mode query outside config mode stretches a digital frame
        '{OP_FRAME,  1'b0, 8'h00,       '0, 1'b1, '{IDLE_BYTE, MOTOR_NONE, 16'h0000, 1'b0}},
        '{OP_BYTE,   1'b0, CMD_QMODE,   '0, 1'b0, NO_CHECK},
        '{OP_BYTE,   1'b0, 8'h00,       '0, 1'b0, NO_CHECK},
        '{OP_BYTE,   1'b0, SETMOD_ANA,  '0, 1'b0, NO_CHECK},
        '{OP_BYTE,   1'b0, 8'h00,       '0, 1'b0, NO_CHECK},
        '{OP_BYTE,   1'b0, 8'h00,       '0, 1'b0, NO_CHECK},
        '{OP_BYTE,   1'b0, 8'h00,       '0, 1'b0, NO_CHECK},
        // unknown command answers zero on data bytes
        '{OP_FRAME,  1'b0, 8'h00,       '0, 1'b0, NO_CHECK},
        '{OP_BYTE,   1'b0, CMD_UNKNOWN, '0, 1'b0, NO_CHECK},
        '{OP_BYTE,   1'b0, 8'h00,       '0, 1'b0, NO_CHECK},
        '{OP_BYTE,   1'b0, 8'hff,       '0, 1'b0, NO_CHECK}
    };

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata  = '0;    // [7:0] host_byte, [55:8] pad bytes first..left_y
    logic [2:0]  s_tuser  = '0;    // [1:0] op, [2] port
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;          // [7:0] reply_byte, [23:8] motor_strength, [24] analog_led
    logic [1:0]  m_tuser;          // [1:0] motor_kind
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [3:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    game_pad_serial_responder dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Predictor state: per-port pad state plus the frame being answered
    logic       pa_analog [2];
    logic       pa_cfg [2];
    logic       pa_lock [2];
    logic       pa_changed [2];
    pad_set_t   pa_pad [2];
    logic       fr_port;
    logic [7:0] fr_cmd;
    logic [7:0] fr_pos;
    logic [7:0] fr_arg;
    logic [2:0] fr_len;
    logic [7:0] code_digital;
    logic [7:0] code_analog;

    result_t replies_due [$];
    int      mismatches   = 0;
    int      sent         = 0;
    bit      sender_burst = 1'b0;
    bit      long_hold    = 1'b0;

    function automatic void reset_model();
        for (int i = 0; i < 2; i++) begin
            pa_analog[i]  = 1'b0;
            pa_cfg[i]     = 1'b0;
            pa_lock[i]    = 1'b0;
            pa_changed[i] = 1'b0;
            pa_pad[i]     = PAD_RESET;
        end
        fr_port      = 1'b0;
        fr_cmd       = '0;
        fr_pos       = '0;
        fr_arg       = '0;
        fr_len       = '0;
        code_digital = DIGITAL_CODE_RESET;
        code_analog  = ANALOG_CODE_RESET;
    endfunction

    // Advance the predictor by one request and return the reply it calls for
    function automatic result_t predict_reply(op_t op, logic port, logic [7:0] hb,
                                              pad_set_t pad);
        result_t    r;
        logic       p;
        logic       cfg;
        logic       flag;
        logic [7:0] d;
        logic [2:0] at;
        r = '0;
        p = port;
        case (op)
            OP_FRAME: begin
                fr_port = port;
                fr_pos = '0;
                r.reply_byte = IDLE_BYTE;
            end
            OP_BYTE: begin
                p = fr_port;
                cfg = pa_cfg[p];
                if (fr_pos == 8'd0) begin
                    fr_cmd = hb;
                    fr_len = (cfg || pa_analog[p]) ? FLEN_LONG : FLEN_SHORT;
                    r.reply_byte = cfg ? ID_CONFIG : (pa_analog[p] ? ID_ANALOG : ID_DIGITAL);
                end else if (fr_pos == 8'd1) begin
                    r.reply_byte = pa_changed[p] ? 8'h00 : ACK_BYTE;
                    pa_changed[p] = 1'b0;
                end else begin
                    d = fr_pos - 8'd2;
                    if (!cfg && (fr_cmd inside {CMD_SETMOD, CMD_MODEL, CMD_ACT, CMD_COMB,
                                                CMD_QMODE, CMD_ALIGN}))
                        fr_len = FLEN_LONG;
                    // data bytes beyond the frame answer zero and change nothing
                    if (d < {5'd0, fr_len}) begin
                        if (d == 8'd0) fr_arg = hb;
                        case (fr_cmd)
                            CMD_READ: begin
                                if (d == 8'd1) begin
                                    r.motor_kind = MOTOR_SMALL;
                                    r.motor_strength = (hb != 8'h00) ? 16'hffff : 16'h0000;
                                end else if (d == 8'd0) begin
                                    r.motor_kind = MOTOR_BIG;
                                    r.motor_strength = {hb, 8'h00};
                                end
                                r.reply_byte = pa_pad[p][d[2:0]];
                            end
                            CMD_CONFIG: begin
                                r.reply_byte = cfg ? 8'h00 : pa_pad[p][d[2:0]];
                                at = (fr_len > FLEN_SHORT) ? fr_len - 3'd2 : 3'd1;
                                if (d != 8'd0 && d == {5'd0, at}) pa_cfg[p] = (fr_arg != 8'h00);
                            end
                            CMD_MODEL: begin
                                case (d)
                                    8'd0:    r.reply_byte = 8'h01;
                                    8'd1:    r.reply_byte = 8'h02;
                                    8'd2:    r.reply_byte = pa_analog[p] ? 8'h01 : 8'h00;
                                    8'd3:    r.reply_byte = 8'h02;
                                    8'd4:    r.reply_byte = 8'h01;
                                    default: r.reply_byte = 8'h00;
                                endcase
                            end
                            CMD_ACT: begin
                                if (d == 8'd3) r.reply_byte = (fr_arg != 0) ? 8'h00 : 8'h02;
                                else if (d == 8'd4) r.reply_byte = (fr_arg != 0) ? 8'h01 : 8'h00;
                                else if (d == 8'd5)
                                    r.reply_byte = (fr_arg != 0) ? ACT_STRONG : ACT_WEAK;
                            end
                            CMD_COMB: begin
                                if (d == 8'd2) r.reply_byte = 8'h02;
                            end
                            CMD_QMODE: begin
                                if (d == 8'd3)
                                    r.reply_byte = (fr_arg != 0) ? code_analog : code_digital;
                            end
                            CMD_SETMOD: begin
                                if (d == 8'd0) begin
                                    flag = (hb == SETMOD_ANA);
                                    if (flag != pa_analog[p]) pa_changed[p] = 1'b1;
                                    pa_analog[p] = flag;
                                end else if (d == 8'd1) begin
                                    flag = (hb == SETMOD_LOCK);
                                    if (flag != pa_lock[p]) pa_changed[p] = 1'b1;
                                    pa_lock[p] = flag;
                                end
                            end
                            CMD_ALIGN: begin
                                if (d == 8'd1) r.reply_byte = 8'h01;
                                else if (d != 8'd0) r.reply_byte = 8'hff;
                            end
                            default: r.reply_byte = 8'h00;
                        endcase
                    end
                end
                if (fr_pos != 8'hff) fr_pos = fr_pos + 8'd1;
            end
            OP_LOAD:   pa_pad[port] = pad;
            OP_TOGGLE: pa_analog[port] = !pa_analog[port];
            default: ;
        endcase
        r.analog_led = pa_analog[p];
        return r;
    endfunction

    // Gap after a request: mostly none or short, now and then long
    function automatic int sender_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (sender_burst || roll < 55) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(5, 25);
    endfunction

    // Offer one request, hold it until taken, then log the reply it should get
    task automatic send_request(op_t op, logic port, logic [7:0] hb, pad_set_t pad,
                                logic checked, result_t want);
        result_t r;
        int      gap;
        s_tvalid <= 1'b1;
        s_tdata  <= {pad, hb};
        s_tuser  <= {port, op};
        do @(posedge aclk); while (!s_tready);
        r = predict_reply(op, port, hb, pad);
        replies_due.push_back(checked ? want : r);
        sent++;
        @(negedge aclk);
        gap = sender_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
    endtask

    // Hold off new requests until every reply is back
    task automatic drain();
        s_tvalid <= 1'b0;
        while (replies_due.size() != 0) @(negedge aclk);
        repeat (TAIL_CYCLES) @(negedge aclk);
    endtask

    task automatic reg_write(logic [1:0] idx, logic [7:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'h0, val};
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        case (idx)
            REG_DIGITAL_CODE: code_digital = val;
            REG_ANALOG_CODE:  code_analog = val;
            REG_PORT0_START:  pa_analog[0] = val[0];
            REG_PORT1_START:  pa_analog[1] = val[0];
            default: ;
        endcase
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Host byte for frame position k: arguments lean toward meaningful values
    function automatic logic [7:0] frame_byte(logic [7:0] cmd, int k);
        int roll;
        roll = $urandom_range(0, 99);
        if (k == 2 && cmd != CMD_READ) begin
            if (roll < 40) return 8'h00;
            if (roll < 80) return SETMOD_ANA;
        end
        if (k == 3 && cmd == CMD_SETMOD && roll < 50) return SETMOD_LOCK;
        return 8'($urandom);
    endfunction

    function automatic pad_set_t random_pad();
        return {16'($urandom), 32'($urandom)};
    endfunction

    // Mostly well-formed frames with random content, the rest loose requests
    task automatic random_phase(int target);
        int         roll;
        int         n;
        logic       port;
        logic [7:0] cmd;
        while (sent < target) begin
            roll = $urandom_range(0, 99);
            sender_burst = ($urandom_range(0, 3) == 0);
            port = 1'($urandom);
            if (roll < 75) begin
                send_request(OP_FRAME, port, 8'($urandom), random_pad(), 1'b0, NO_CHECK);
                case ($urandom_range(0, 9))
                    0:       cmd = CMD_READ;
                    1, 2:    cmd = CMD_CONFIG;
                    3:       cmd = CMD_SETMOD;
                    4:       cmd = CMD_MODEL;
                    5:       cmd = CMD_ACT;
                    6:       cmd = CMD_COMB;
                    7:       cmd = CMD_QMODE;
                    8:       cmd = CMD_ALIGN;
                    default: cmd = 8'($urandom);
                endcase
                n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 10) : 8;
                for (int k = 0; k < n; k++) begin
                    if ($urandom_range(0, 19) == 0)
                        send_request($urandom_range(0, 1) ? OP_LOAD : OP_TOGGLE, 1'($urandom),
                                     8'($urandom), random_pad(), 1'b0, NO_CHECK);
                    send_request(OP_BYTE, 1'($urandom), (k == 0) ? cmd : frame_byte(cmd, k),
                                 random_pad(), 1'b0, NO_CHECK);
                end
            end else if (roll < 85) begin
                send_request(OP_LOAD, port, 8'($urandom), random_pad(), 1'b0, NO_CHECK);
            end else if (roll < 92) begin
                send_request(OP_TOGGLE, port, 8'($urandom), random_pad(), 1'b0, NO_CHECK);
            end else begin
                send_request(op_t'($urandom_range(0, 3)), port, 8'($urandom), random_pad(),
                             1'b0, NO_CHECK);
            end
        end
    endtask

    // Result side ready pattern, with one long hold on request
    initial begin : result_sink
        int stall;
        int run;
        int roll;
        stall = 0;
        run = 0;
        forever begin
            @(negedge aclk);
            if (long_hold) begin
                long_hold = 1'b0;
                stall = LONG_HOLD;
                run = 0;
            end
            if (stall == 0 && run == 0) begin
                roll = $urandom_range(0, 99);
                if (roll < 50) run = $urandom_range(1, 30);
                else if (roll < 90) stall = $urandom_range(1, 3);
                else stall = $urandom_range(8, 40);
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                stall--;
            end else begin
                m_tready <= 1'b1;
                run--;
            end
        end
    end

    // Compare each accepted result with the oldest expected reply
    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = '{m_tdata[7:0], m_tuser, m_tdata[23:8], m_tdata[24]};
            if (replies_due.size() == 0) begin
                $display("%0t: unexpected result reply %h kind %0d strength %h led %b",
                         $time, got.reply_byte, got.motor_kind, got.motor_strength,
                         got.analog_led);
                mismatches++;
            end else begin
                want = replies_due.pop_front();
                if (got !== want) begin
                    $display("%0t: expected reply %h kind %0d strength %h led %b, got reply %h kind %0d strength %h led %b",
                             $time, want.reply_byte, want.motor_kind, want.motor_strength,
                             want.analog_led, got.reply_byte, got.motor_kind,
                             got.motor_strength, got.analog_led);
                    mismatches++;
                end
            end
        end
    end

    initial begin : stimulus
        logic [7:0] dig;
        logic [7:0] ana;
        logic       start0;
        logic       start1;
        reset_model();
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (SCRIPT[i])
            send_request(SCRIPT[i].op, SCRIPT[i].port, SCRIPT[i].host_byte, SCRIPT[i].pad,
                         SCRIPT[i].checked, SCRIPT[i].want);
        random_phase(PHASE_ITEMS);

        for (int ph = 1; ph < 5; ph++) begin
            drain();
            case (ph)
                1:       begin dig = 8'h00; ana = 8'hff; start0 = 1'b1; start1 = 1'b0; end
                2:       begin dig = 8'hff; ana = 8'h00; start0 = 1'b0; start1 = 1'b1; end
                3:       begin dig = 8'h5a; ana = 8'h5a; start0 = 1'b1; start1 = 1'b1; end
                default: begin
                    dig = 8'($urandom);
                    ana = 8'($urandom);
                    start0 = 1'($urandom);
                    start1 = 1'($urandom);
                end
            endcase
            reg_write(REG_DIGITAL_CODE, dig);
            reg_write(REG_ANALOG_CODE, ana);
            reg_write(REG_PORT0_START, {7'd0, start0});
            reg_write(REG_PORT1_START, {7'd0, start1});
            // stall the result side while requests keep coming
            if (ph == 1) long_hold = 1'b1;
            // run the byte position into saturation
            if (ph == 4) begin
                sender_burst = 1'b1;
                send_request(OP_FRAME, 1'b0, 8'h00, '0, 1'b0, NO_CHECK);
                for (int k = 0; k < 262; k++)
                    send_request(OP_BYTE, 1'b0, (k == 0) ? CMD_READ : 8'($urandom),
                                 random_pad(), 1'b0, NO_CHECK);
            end
            random_phase(PHASE_ITEMS * (ph + 1));
        end
        drain();

        if (mismatches == 0 && replies_due.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin : watchdog
        #(RUN_LIMIT_NS);
        $display("status: fail");
        $finish;
    end

endmodule

>>> filelist.f
src/gpsr_pkg.sv
src/gpsr_cfg_regs.sv
src/gpsr_core.sv
src/game_pad_serial_responder.sv
tb/tb_game_pad_serial_responder.sv
